/* sv/dsl_pkg.sv */
// Shared types, constants and arithmetic helpers for the dense sigmoid layer.
package dsl_pkg;

    localparam int MAX_INPUTS_DEF  = 64;
    localparam int MAX_OUTPUTS_DEF = 64;

    localparam int SIG_SIZE = 1024;
    localparam int SIG_HALF = 512;

    localparam logic [6:0]  INPUTS_RST  = 7'd64;
    localparam logic [6:0]  OUTPUTS_RST = 7'd64;
    localparam logic [15:0] RATE_RST    = 16'd655;

    localparam logic [1:0] CFG_INPUTS  = 2'd0;
    localparam logic [1:0] CFG_OUTPUTS = 2'd1;
    localparam logic [1:0] CFG_RATE    = 2'd2;

    localparam logic [1:0] ACT_WEIGHT = 2'd0;
    localparam logic [1:0] ACT_BIAS   = 2'd1;
    localparam logic [1:0] ACT_INPUT  = 2'd2;
    localparam logic [1:0] ACT_TARGET = 2'd3;

    localparam logic KIND_FWD   = 1'b0;
    localparam logic KIND_TRAIN = 1'b1;

    typedef logic [16:0] sig_rom_t [SIG_SIZE];

    typedef enum logic [4:0] {
        ST_IDLE, ST_BIAS_RD, ST_BIAS_LD, ST_MAC_RD, ST_MAC_MUL, ST_MAC_ACC, ST_SIG,
        ST_FWD_EMIT, ST_T_ERR, ST_T_SLOPE, ST_T_DELTA, ST_G_RD, ST_G_M1, ST_G_M2,
        ST_G_M3, ST_G_M4, ST_B_RD, ST_B_M, ST_B_W, ST_O_RD, ST_O_M, ST_O_EMIT
    } dsl_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_BIAS_RD, OP_BIAS_LD, OP_MAC_RD, OP_MAC_MUL, OP_MAC_ACC, OP_SIG,
        OP_FWD_EMIT, OP_T_ERR, OP_T_SLOPE, OP_T_DELTA, OP_G_RD, OP_G_M1, OP_G_M2,
        OP_G_M3, OP_G_M4, OP_B_RD, OP_B_M, OP_B_W, OP_O_RD, OP_O_M, OP_O_EMIT
    } dsl_op_t;

    typedef struct packed {
        dsl_op_t op;
        logic    accept;
        logic    train;
    } dsl_cmd_t;

    typedef struct packed {
        logic start_fwd;
        logic start_train;
        logic j_last;
        logic i_last;
        logic out_free;
    } dsl_sts_t;

    function automatic sig_rom_t build_sig();
        logic [95:0] e;
        logic [95:0] den;
        logic [95:0] num;
        logic [95:0] rem;
        logic [95:0] q;
        logic [16:0] pos [SIG_HALF + 1];
        sig_rom_t    t;
        e = 96'd1 << 32;
        for (int m = 0; m <= SIG_HALF; m++)
        begin
            den = (96'd1 << 32) + e;
            num = (96'd1 << 48) + (den >> 1);
            rem = '0;
            q   = '0;
            for (int b = 49; b >= 0; b--)
            begin
                rem = {rem[94:0], num[b]};
                if (rem >= den)
                begin
                    rem  = rem - den;
                    q[b] = 1'b1;
                end
            end
            pos[m] = q[16:0];
            e      = (e * 96'd4228380000) >> 32;
        end
        for (int m = 0; m < SIG_SIZE; m++)
        begin
            if (m >= SIG_HALF)
                t[m] = pos[m - SIG_HALF];
            else
                t[m] = 17'd65536 - pos[SIG_HALF - m];
        end
        return t;
    endfunction

    localparam sig_rom_t SIG_ROM = build_sig();

    function automatic logic signed [31:0] sat48(input logic signed [47:0] v);
        if (v > 48'sd2147483647)
            return 32'sh7FFFFFFF;
        else if (v < -48'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        if (v[32] != v[31])
            return v[32] ? 32'sh80000000 : 32'sh7FFFFFFF;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] mulq(input logic signed [63:0] p);
        return sat48(p[63:16]);
    endfunction

endpackage

/* sv/dsl_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module dsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic                                     re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end
endmodule

/* sv/dsl_ctrl.sv */
// Sequencing state machine for load, forward and training passes.
module dsl_ctrl
    import dsl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  dsl_sts_t sts,
    output dsl_cmd_t cmd
);
    dsl_state_t state_reg, state_next;
    logic       mode_reg, mode_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            mode_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        mode_next  = mode_reg;
        cmd.op     = OP_NONE;
        cmd.accept = 1'b0;
        cmd.train  = mode_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.accept = 1'b1;
                if (sts.start_fwd)
                begin
                    mode_next  = 1'b0;
                    state_next = ST_BIAS_RD;
                end
                else if (sts.start_train)
                begin
                    mode_next  = 1'b1;
                    state_next = ST_BIAS_RD;
                end
            end
            ST_BIAS_RD:
            begin
                cmd.op     = OP_BIAS_RD;
                state_next = ST_BIAS_LD;
            end
            ST_BIAS_LD:
            begin
                cmd.op     = OP_BIAS_LD;
                state_next = ST_MAC_RD;
            end
            ST_MAC_RD:
            begin
                cmd.op     = OP_MAC_RD;
                state_next = ST_MAC_MUL;
            end
            ST_MAC_MUL:
            begin
                cmd.op     = OP_MAC_MUL;
                state_next = ST_MAC_ACC;
            end
            ST_MAC_ACC:
            begin
                cmd.op     = OP_MAC_ACC;
                state_next = sts.j_last ? ST_SIG : ST_MAC_RD;
            end
            ST_SIG:
            begin
                cmd.op     = OP_SIG;
                state_next = mode_reg ? ST_T_ERR : ST_FWD_EMIT;
            end
            ST_FWD_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_FWD_EMIT;
                    state_next = sts.i_last ? ST_IDLE : ST_BIAS_RD;
                end
            end
            ST_T_ERR:
            begin
                cmd.op     = OP_T_ERR;
                state_next = ST_T_SLOPE;
            end
            ST_T_SLOPE:
            begin
                cmd.op     = OP_T_SLOPE;
                state_next = ST_T_DELTA;
            end
            ST_T_DELTA:
            begin
                cmd.op     = OP_T_DELTA;
                state_next = ST_G_RD;
            end
            ST_G_RD:
            begin
                cmd.op     = OP_G_RD;
                state_next = ST_G_M1;
            end
            ST_G_M1:
            begin
                cmd.op     = OP_G_M1;
                state_next = ST_G_M2;
            end
            ST_G_M2:
            begin
                cmd.op     = OP_G_M2;
                state_next = ST_G_M3;
            end
            ST_G_M3:
            begin
                cmd.op     = OP_G_M3;
                state_next = ST_G_M4;
            end
            ST_G_M4:
            begin
                cmd.op     = OP_G_M4;
                state_next = sts.j_last ? ST_B_RD : ST_G_RD;
            end
            ST_B_RD:
            begin
                cmd.op     = OP_B_RD;
                state_next = ST_B_M;
            end
            ST_B_M:
            begin
                cmd.op     = OP_B_M;
                state_next = ST_B_W;
            end
            ST_B_W:
            begin
                cmd.op     = OP_B_W;
                state_next = sts.i_last ? ST_O_RD : ST_BIAS_RD;
            end
            ST_O_RD:
            begin
                cmd.op     = OP_O_RD;
                state_next = ST_O_M;
            end
            ST_O_M:
            begin
                cmd.op     = OP_O_M;
                state_next = ST_O_EMIT;
            end
            ST_O_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.op     = OP_O_EMIT;
                    state_next = sts.j_last ? ST_IDLE : ST_O_RD;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

`ifndef NO_ASSERTIONS
    a_start_train: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && sts.start_train) |=> (mode_reg && state_reg == ST_BIAS_RD))
        else $error("training start did not enter the bias read in training mode");
    a_busy_no_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !cmd.accept)
        else $error("item accepted while a pass is running");
`endif
endmodule

/* sv/dsl_dp.sv */
// Datapath: weight, bias, input, target and gradient stores, shared multiplier, result register.
module dsl_dp
    import dsl_pkg::*;
#(
    parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
    parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dsl_cmd_t           cmd,
    output dsl_sts_t           sts,
    input  logic               in_valid,
    input  logic [1:0]         action,
    input  logic [5:0]         row,
    input  logic [5:0]         col,
    input  logic signed [31:0] value,
    input  logic               last,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    input  logic               out_ready,
    output logic               out_valid,
    output logic               kind,
    output logic [5:0]         index,
    output logic signed [31:0] result_value,
    output logic               end_of_run
);
    localparam int IW  = MAX_INPUTS > 1 ? $clog2(MAX_INPUTS) : 1;
    localparam int OW  = MAX_OUTPUTS > 1 ? $clog2(MAX_OUTPUTS) : 1;
    localparam int CWI = $clog2(MAX_INPUTS + 1);
    localparam int CWO = $clog2(MAX_OUTPUTS + 1);
    localparam int WDEPTH = 2 ** (IW + OW);

    logic [6:0]  nin_reg, nout_reg;
    logic [15:0] rate_reg;
    logic [CWI-1:0] nin_eff, j_reg;
    logic [CWO-1:0] nout_eff, i_reg;
    logic [10:0] nin_w, nout_w;

    logic signed [31:0] acc_reg, sig_reg, err_reg, delta_reg;
    logic signed [63:0] prod_reg;
    logic signed [31:0] mul_a, mul_b;
    logic               mul_en;

    logic [MAX_INPUTS-1:0] x_valid_reg, g_valid_reg;
    logic x_vq_reg, g_vq_reg;

    logic out_valid_reg, kind_reg, end_reg;
    logic [5:0] index_reg;
    logic signed [31:0] value_reg;

    logic in_fire, row_ok, col_ok;
    logic signed [31:0] w_rd, b_rd, x_rd, t_rd, g_rd, xv, gv, prodq, prodr;
    logic w_we, b_we, x_we, t_we, g_we;
    logic [IW+OW-1:0] w_waddr, w_raddr;
    logic [OW-1:0] b_waddr, t_waddr;
    logic [IW-1:0] x_waddr;
    logic signed [31:0] w_wdata, b_wdata;
    logic signed [32:0] off;
    logic [9:0] sig_idx;

    // Configuration registers; the port is always ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nin_reg  <= INPUTS_RST;
            nout_reg <= OUTPUTS_RST;
            rate_reg <= RATE_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INPUTS:  nin_reg  <= cfg_data[6:0];
                CFG_OUTPUTS: nout_reg <= cfg_data[6:0];
                CFG_RATE:    rate_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        nin_w  = {4'b0, nin_reg};
        nout_w = {4'b0, nout_reg};
        if (nin_w == 11'd0)
            nin_eff = CWI'(1);
        else if (nin_w > 11'(MAX_INPUTS))
            nin_eff = CWI'(MAX_INPUTS);
        else
            nin_eff = CWI'(nin_w);
        if (nout_w == 11'd0)
            nout_eff = CWO'(1);
        else if (nout_w > 11'(MAX_OUTPUTS))
            nout_eff = CWO'(MAX_OUTPUTS);
        else
            nout_eff = CWO'(nout_w);
    end

    assign in_fire = in_valid && cmd.accept;
    assign row_ok  = {5'b0, row} < 11'(MAX_OUTPUTS);
    assign col_ok  = {5'b0, col} < 11'(MAX_INPUTS);

    assign sts.start_fwd   = in_fire && action == ACT_INPUT && last;
    assign sts.start_train = in_fire && action == ACT_TARGET && last;
    assign sts.j_last      = ({1'b0, j_reg} + 1'b1) == {1'b0, nin_eff};
    assign sts.i_last      = ({1'b0, i_reg} + 1'b1) == {1'b0, nout_eff};
    assign sts.out_free    = !out_valid_reg || out_ready;

    assign xv    = x_vq_reg ? x_rd : 32'sd0;
    assign gv    = g_vq_reg ? g_rd : 32'sd0;
    assign prodq = mulq(prod_reg);
    assign prodr = prod_reg[47:16];

    // Store write ports: loads while idle, updates during training.
    always_comb
    begin
        w_we    = 1'b0;
        w_waddr = {OW'(row), IW'(col)};
        w_wdata = value;
        b_we    = 1'b0;
        b_waddr = OW'(row);
        b_wdata = value;
        x_we    = in_fire && action == ACT_INPUT && col_ok;
        x_waddr = IW'(col);
        t_we    = in_fire && action == ACT_TARGET && row_ok;
        t_waddr = OW'(row);
        g_we    = cmd.op == OP_G_M2;
        if (in_fire && action == ACT_WEIGHT && row_ok && col_ok)
            w_we = 1'b1;
        if (in_fire && action == ACT_BIAS && row_ok)
            b_we = 1'b1;
        if (cmd.op == OP_G_M4)
        begin
            w_we    = 1'b1;
            w_waddr = {i_reg[OW-1:0], j_reg[IW-1:0]};
            w_wdata = sat33(33'(w_rd) - 33'(prodr));
        end
        if (cmd.op == OP_B_W)
        begin
            b_we    = 1'b1;
            b_waddr = i_reg[OW-1:0];
            b_wdata = sat33(33'(b_rd) - 33'(prodr));
        end
    end

    assign w_raddr = {i_reg[OW-1:0], j_reg[IW-1:0]};

    dsl_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_w_ram (
        .clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
        .re(cmd.op == OP_MAC_RD || cmd.op == OP_G_RD), .raddr(w_raddr), .rdata(w_rd)
    );

    dsl_ram #(.WIDTH(32), .DEPTH(2 ** OW)) u_b_ram (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
        .re(cmd.op == OP_BIAS_RD || cmd.op == OP_B_RD), .raddr(i_reg[OW-1:0]), .rdata(b_rd)
    );

    dsl_ram #(.WIDTH(32), .DEPTH(2 ** IW)) u_x_ram (
        .clk(clk), .we(x_we), .waddr(x_waddr), .wdata(value),
        .re(cmd.op == OP_MAC_RD || cmd.op == OP_G_RD || cmd.op == OP_O_RD),
        .raddr(j_reg[IW-1:0]), .rdata(x_rd)
    );

    dsl_ram #(.WIDTH(32), .DEPTH(2 ** OW)) u_t_ram (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(value),
        .re(cmd.op == OP_SIG), .raddr(i_reg[OW-1:0]), .rdata(t_rd)
    );

    dsl_ram #(.WIDTH(32), .DEPTH(2 ** IW)) u_g_ram (
        .clk(clk), .we(g_we), .waddr(j_reg[IW-1:0]),
        .wdata(sat33(33'(gv) + 33'(prodq))),
        .re(cmd.op == OP_G_RD || cmd.op == OP_O_RD), .raddr(j_reg[IW-1:0]), .rdata(g_rd)
    );

    // Shared 32x32 multiplier operand selection.
    always_comb
    begin
        mul_en = 1'b1;
        mul_a  = w_rd;
        mul_b  = xv;
        case (cmd.op)
            OP_MAC_MUL:
            begin
                mul_a = w_rd;
                mul_b = xv;
            end
            OP_T_ERR:
            begin
                mul_a = sig_reg;
                mul_b = 32'sd65536 - sig_reg;
            end
            OP_T_SLOPE:
            begin
                mul_a = err_reg;
                mul_b = prodq;
            end
            OP_G_M1:
            begin
                mul_a = delta_reg;
                mul_b = w_rd;
            end
            OP_G_M2:
            begin
                mul_a = delta_reg;
                mul_b = xv;
            end
            OP_G_M3:
            begin
                mul_a = $signed({16'b0, rate_reg});
                mul_b = prodq;
            end
            OP_B_M:
            begin
                mul_a = $signed({16'b0, rate_reg});
                mul_b = delta_reg;
            end
            OP_O_M:
            begin
                mul_a = $signed({16'b0, rate_reg});
                mul_b = gv;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        off = $signed({acc_reg[31], acc_reg}) + 33'sd524288;
        if (off[32])
            sig_idx = 10'd0;
        else if (|off[31:20])
            sig_idx = 10'd1023;
        else
            sig_idx = off[19:10];
    end

    always_ff @(posedge clk)
    begin
        if (mul_en)
            prod_reg <= mul_a * mul_b;
        case (cmd.op)
            OP_BIAS_LD: acc_reg <= b_rd;
            OP_MAC_ACC: acc_reg <= sat33(33'(acc_reg) + 33'(prodq));
            OP_SIG:     sig_reg <= 32'(SIG_ROM[sig_idx]);
            OP_T_ERR:   err_reg <= sat48(48'(33'(sig_reg) - 33'(t_rd)) <<< 1);
            OP_T_DELTA: delta_reg <= prodq;
            default:    ;
        endcase
        if (cmd.op == OP_MAC_RD || cmd.op == OP_G_RD || cmd.op == OP_O_RD)
        begin
            x_vq_reg <= x_valid_reg[j_reg[IW-1:0]];
            g_vq_reg <= g_valid_reg[j_reg[IW-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            x_valid_reg   <= '0;
            g_valid_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (x_we)
                x_valid_reg[x_waddr] <= 1'b1;
            if (sts.start_train)
                g_valid_reg <= '0;
            else if (g_we)
                g_valid_reg[j_reg[IW-1:0]] <= 1'b1;
            if (sts.start_fwd || sts.start_train)
            begin
                i_reg <= '0;
                j_reg <= '0;
            end
            case (cmd.op)
                OP_BIAS_LD, OP_T_DELTA: j_reg <= '0;
                OP_MAC_ACC, OP_G_M4, OP_O_EMIT: j_reg <= j_reg + 1'b1;
                OP_FWD_EMIT: i_reg <= i_reg + 1'b1;
                OP_B_W:
                begin
                    i_reg <= i_reg + 1'b1;
                    j_reg <= '0;
                end
                default: ;
            endcase
            if (cmd.op == OP_FWD_EMIT || cmd.op == OP_O_EMIT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_FWD_EMIT)
        begin
            kind_reg  <= KIND_FWD;
            index_reg <= 6'(i_reg);
            value_reg <= sig_reg;
            end_reg   <= sts.i_last;
        end
        else if (cmd.op == OP_O_EMIT)
        begin
            kind_reg  <= KIND_TRAIN;
            index_reg <= 6'(j_reg);
            value_reg <= sat33(33'(xv) - 33'(prodr));
            end_reg   <= sts.j_last;
        end
    end

    assign out_valid    = out_valid_reg;
    assign kind         = kind_reg;
    assign index        = index_reg;
    assign result_value = value_reg;
    assign end_of_run   = end_reg;

`ifndef NO_ASSERTIONS
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FWD_EMIT || cmd.op == OP_O_EMIT) |-> sts.out_free)
        else $error("result register overwritten before transfer");
    a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op != OP_NONE) |-> ({1'b0, j_reg} <= {1'b0, nin_eff}))
        else $error("input counter ran past the inputs in use");
    a_fwd_end: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_FWD_EMIT) |=> (end_reg == (index_reg == 6'(nout_eff - 1'b1))))
        else $error("forward end mark not on the last neuron");
`endif
endmodule

/* sv/dense_sigmoid_layer_sgd.sv */
// Top level of the dense sigmoid layer trained in place by one SGD step.
// A load item (weight, bias, input or target) is taken only while no pass runs. An
// input item marked last runs a forward pass; a target item marked last runs a
// training step. Both passes are paced by the single shared 32x32 multiplier,
// which serves one multiply per step, and by the single read port of the weight
// RAM. Results leave through an output register; a stalled output holds the pass.
module dense_sigmoid_layer_sgd
    import dsl_pkg::*;
#(
    parameter int MAX_INPUTS  = MAX_INPUTS_DEF,
    parameter int MAX_OUTPUTS = MAX_OUTPUTS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [5:0]         row,
    input  logic [5:0]         col,
    input  logic signed [31:0] value,
    input  logic               last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               kind,
    output logic [5:0]         index,
    output logic signed [31:0] result_value,
    output logic               end_of_run
);
    dsl_cmd_t cmd;
    dsl_sts_t sts;

    assign in_ready  = cmd.accept;
    assign cfg_ready = 1'b1;

    dsl_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .sts(sts), .cmd(cmd)
    );

    dsl_dp #(.MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
        .in_valid(in_valid), .action(action), .row(row), .col(col), .value(value),
        .last(last), .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .out_ready(out_ready), .out_valid(out_valid), .kind(kind), .index(index),
        .result_value(result_value), .end_of_run(end_of_run)
    );
endmodule
